/* hw/rtl/pfsa_pkg.sv */
// Shared types and constants of the page frame stack allocator.
`timescale 1ns / 1ps

package pfsa_pkg;

    localparam int STACK_DEPTH    = 65536;
    localparam int PAGE_BYTES     = 4096;
    localparam int ADDR_BITS      = 48;

    localparam int PAGE_SHIFT     = $clog2(PAGE_BYTES);
    localparam int PFN_BITS       = ADDR_BITS - PAGE_SHIFT;
    localparam int IDX_BITS       = $clog2(STACK_DEPTH);
    localparam int TOP_BITS       = IDX_BITS + 1;
    localparam int COUNT_BITS     = 36;
    localparam int FREE_BITS      = 17;
    localparam int RESV_NUM       = 4;
    localparam int RESV_SEL_BITS  = $clog2(RESV_NUM);
    localparam int CFG_IDX_BITS   = RESV_SEL_BITS + 1;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_ADD   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_RSET1,
        S_RSET2,
        S_WALK
    } t_state;

    typedef struct packed {
        t_op                    operation;
        logic [ADDR_BITS-1:0]   address;
        logic [COUNT_BITS-1:0]  page_count;
    } t_req;

    typedef struct packed {
        logic [ADDR_BITS-1:0]   page_address;
        t_status                status;
        logic [FREE_BITS-1:0]   free_count;
    } t_rsp;

    typedef struct packed {
        logic                   hit;
        logic [PFN_BITS-1:0]    start_pfn;
    } t_resv_hit;

endpackage

/* hw/rtl/pfsa_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read.
`timescale 1ns / 1ps

module pfsa_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/pfsa_resv.sv */
// Reserved range registers and the page hit check against them.
`timescale 1ns / 1ps

module pfsa_resv (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [pfsa_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [pfsa_pkg::ADDR_BITS-1:0]       i_cfg_data,
    input  logic [pfsa_pkg::PFN_BITS-1:0]        i_pfn,
    output pfsa_pkg::t_resv_hit                  o_hit
);
    import pfsa_pkg::*;

    logic [PFN_BITS-1:0]      r_rs [RESV_NUM];
    logic [PFN_BITS:0]        r_re [RESV_NUM];
    logic [RESV_SEL_BITS-1:0] cfg_sel;
    logic [PFN_BITS:0]        end_up;

    assign cfg_sel = i_cfg_idx[CFG_IDX_BITS-1:1];
    assign end_up  = {1'b0, i_cfg_data[ADDR_BITS-1:PAGE_SHIFT]}
                   + (PFN_BITS+1)'(|i_cfg_data[PAGE_SHIFT-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < RESV_NUM; i++) begin
                r_rs[i] <= '0;
                r_re[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx[0]) begin
                r_re[cfg_sel] <= end_up;
            end else begin
                r_rs[cfg_sel] <= i_cfg_data[ADDR_BITS-1:PAGE_SHIFT];
            end
        end
    end

    // lowest numbered range wins
    always_comb begin
        o_hit = '0;
        for (int i = RESV_NUM - 1; i >= 0; i--) begin
            if (r_rs[i] <= i_pfn && {1'b0, i_pfn} < r_re[i]) begin
                o_hit.hit       = 1'b1;
                o_hit.start_pfn = r_rs[i];
            end
        end
    end

endmodule

/* hw/rtl/page_frame_stack_allocator.sv */
// Top level of the page frame stack allocator: command sequencer and stack.
`timescale 1ns / 1ps

// Accepts a command when i_start is high and o_busy is low, and returns exactly one
// result beat per command on o_rsp, marked by o_done for one cycle; the receiver cannot
// stall it. Free, an empty alloc and the unused operation code answer in the cycle after
// the command; an alloc with pages answers from S_ALLOC, after a registered stack memory
// read. An add range sets up in S_RSET1 and S_RSET2, then walks in S_WALK, jumping over
// each reserved range it meets; the walk pushes one page per cycle into the stack memory,
// save in cycles that jump a range. o_busy is high while a command is in progress.
// The stack memory needs no clearing after reset. The range registers take a write at
// any edge, so write them only while o_busy is low.
module page_frame_stack_allocator (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  pfsa_pkg::t_req                       i_req,
    output logic                                 o_busy,
    output logic                                 o_done,
    output pfsa_pkg::t_rsp                       o_rsp,
    input  logic                                 i_cfg_we,
    input  logic [pfsa_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [pfsa_pkg::ADDR_BITS-1:0]       i_cfg_data
);
    import pfsa_pkg::*;

    t_state                r_state, n_state;
    logic [TOP_BITS-1:0]   r_top, n_top;
    logic                  r_done, n_done;
    t_rsp                  r_rsp, n_rsp;
    logic [ADDR_BITS-1:0]  r_addr;
    logic [COUNT_BITS-1:0] r_cnt;
    logic [ADDR_BITS-1:0]  r_endb, n_endb;
    logic [PFN_BITS-1:0]   r_first, n_first;
    logic                  r_skip, n_skip;
    logic [PFN_BITS-1:0]   r_p, n_p;

    logic                  accept;
    logic                  top_full;
    logic [TOP_BITS-1:0]   top_dec;
    logic                  free_ok;
    logic [ADDR_BITS:0]    end_sum;
    logic [ADDR_BITS:0]    last_diff;
    logic                  range_ok;
    logic                  walk_end;
    t_resv_hit             hit;

    logic                  mem_we;
    logic [IDX_BITS-1:0]   mem_waddr;
    logic [PFN_BITS-1:0]   mem_wdata;
    logic [IDX_BITS-1:0]   mem_raddr;
    logic [PFN_BITS-1:0]   mem_rdata;

    pfsa_ram #(
        .WIDTH (PFN_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    pfsa_resv u_resv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pfn      (r_p),
        .o_hit      (hit)
    );

    assign accept    = i_start && (r_state == S_IDLE);
    assign top_full  = r_top >= TOP_BITS'(STACK_DEPTH);
    assign top_dec   = r_top - TOP_BITS'(1);
    assign mem_raddr = top_dec[IDX_BITS-1:0];
    assign free_ok   = (i_req.address != '0) && (i_req.address[PAGE_SHIFT-1:0] == '0);
    assign end_sum   = {1'b0, r_addr} + (ADDR_BITS+1)'({r_cnt, {PAGE_SHIFT{1'b0}}})
                     - (ADDR_BITS+1)'(1);
    assign last_diff = {1'b0, r_endb} - (ADDR_BITS+1)'(PAGE_BYTES - 1);
    assign range_ok  = !r_skip && !last_diff[ADDR_BITS]
                     && (last_diff[ADDR_BITS-1:PAGE_SHIFT] >= r_first);
    assign walk_end  = hit.hit ? (hit.start_pfn <= r_first) : (top_full || r_p == r_first);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.operation)
                        OP_ALLOC: n_state = (r_top == '0) ? S_IDLE : S_ALLOC;
                        OP_ADD:   n_state = S_RSET1;
                        OP_FREE,
                        OP_NONE:  n_state = S_IDLE;
                        default:  n_state = S_IDLE;
                    endcase
                end
            end
            S_ALLOC: n_state = S_IDLE;
            S_RSET1: n_state = S_RSET2;
            S_RSET2: n_state = range_ok ? S_WALK : S_IDLE;
            S_WALK:  n_state = walk_end ? S_IDLE : S_WALK;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and result
    always_comb begin
        n_top     = r_top;
        n_done    = 1'b0;
        n_rsp     = r_rsp;
        n_endb    = r_endb;
        n_first   = r_first;
        n_skip    = r_skip;
        n_p       = r_p;
        mem_we    = 1'b0;
        mem_waddr = r_top[IDX_BITS-1:0];
        mem_wdata = i_req.address[ADDR_BITS-1:PAGE_SHIFT];
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_rsp.page_address = '0;
                    n_rsp.status       = STAT_OK;
                    unique case (i_req.operation)
                        OP_ALLOC: begin
                            if (r_top == '0) begin
                                n_done       = 1'b1;
                                n_rsp.status = STAT_EMPTY;
                            end else begin
                                n_top = top_dec;
                            end
                        end
                        OP_FREE: begin
                            n_done = 1'b1;
                            if (!free_ok) begin
                                n_rsp.status = STAT_INVALID;
                            end else if (top_full) begin
                                n_rsp.status = STAT_FULL;
                            end else begin
                                mem_we = 1'b1;
                                n_top  = r_top + TOP_BITS'(1);
                            end
                        end
                        OP_ADD: begin
                        end
                        OP_NONE: n_done = 1'b1;
                        default: n_done = 1'b1;
                    endcase
                    n_rsp.free_count = n_top;
                end
            end
            S_ALLOC: begin
                n_done             = 1'b1;
                n_rsp.page_address = {mem_rdata, {PAGE_SHIFT{1'b0}}};
                n_rsp.status       = STAT_OK;
                n_rsp.free_count   = r_top;
            end
            S_RSET1: begin
                n_endb  = end_sum[ADDR_BITS] ? '1 : end_sum[ADDR_BITS-1:0];
                n_first = r_addr[ADDR_BITS-1:PAGE_SHIFT]
                        + PFN_BITS'(|r_addr[PAGE_SHIFT-1:0]);
                n_skip  = (r_cnt == '0)
                        || (&r_addr[ADDR_BITS-1:PAGE_SHIFT] && |r_addr[PAGE_SHIFT-1:0]);
            end
            S_RSET2: begin
                n_p = last_diff[ADDR_BITS-1:PAGE_SHIFT];
                if (!range_ok) begin
                    n_done             = 1'b1;
                    n_rsp.page_address = '0;
                    n_rsp.status       = STAT_OK;
                    n_rsp.free_count   = r_top;
                end
            end
            S_WALK: begin
                n_rsp.page_address = '0;
                n_rsp.status       = STAT_OK;
                if (hit.hit) begin
                    n_p = hit.start_pfn - PFN_BITS'(1);
                end else if (top_full) begin
                    n_rsp.status = STAT_FULL;
                end else begin
                    mem_we    = 1'b1;
                    mem_wdata = r_p;
                    n_top     = r_top + TOP_BITS'(1);
                    n_p       = r_p - PFN_BITS'(1);
                end
                n_rsp.free_count = n_top;
                n_done           = walk_end;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_top   <= n_top;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= i_req.address;
            r_cnt  <= i_req.page_count;
        end
        r_rsp   <= n_rsp;
        r_endb  <= n_endb;
        r_first <= n_first;
        r_skip  <= n_skip;
        r_p     <= n_p;
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
